[sv/vcs_pkg.sv]
`timescale 1ns / 1ps
package vcs_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int IDX_W   = 6;
  localparam int AXIS_W  = 2;
  localparam int ORD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int SEG_W   = 6;
  localparam int PROD_W  = 64;

  localparam logic [KIND_W-1:0] KIND_KNOT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] wide_t;

  function automatic data_t sat32(input wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = wide_t'(64'sh0000_0000_7FFF_FFFF);
    lo_lim = wide_t'(-64'sh0000_0000_8000_0000);
    if (v > hi_lim) begin
      sat32 = data_t'(hi_lim);
    end else if (v < lo_lim) begin
      sat32 = data_t'(lo_lim);
    end else begin
      sat32 = data_t'(v);
    end
  endfunction

endpackage

[sv/vector_cubic_spline_eval.sv]
`timescale 1ns / 1ps
// Evaluates a loaded 3D piecewise cubic spline (Q16.16). Knot and coefficient
// writes go straight into their memories. An evaluate command binary-searches
// the knot memory, each probe a synchronous read and then a compare, then
// streams four coefficients per axis from the coefficient memory and runs
// four multiply/post steps per axis on one shared 32x32 multiplier. done_o is
// high for one cycle when the results are on the ports; the receiver cannot
// stall them. The result ports change again while the next evaluation runs.
module vector_cubic_spline_eval #(
  parameter int MAX_KNOTS = vcs_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = vcs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [vcs_pkg::KIND_W-1:0]    kind_i,
  input  logic [vcs_pkg::IDX_W-1:0]     index_i,
  input  logic [vcs_pkg::AXIS_W-1:0]    axis_i,
  input  logic [vcs_pkg::ORD_W-1:0]     order_i,
  input  vcs_pkg::data_t                value_i,
  input  vcs_pkg::data_t                param_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vcs_pkg::COUNT_W-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [vcs_pkg::SEG_W-1:0]     segment_o,
  output vcs_pkg::data_t                pos_x_o,
  output vcs_pkg::data_t                pos_y_o,
  output vcs_pkg::data_t                pos_z_o,
  output vcs_pkg::data_t                slope_x_o,
  output vcs_pkg::data_t                slope_y_o,
  output vcs_pkg::data_t                slope_z_o,
  output vcs_pkg::data_t                curve_x_o,
  output vcs_pkg::data_t                curve_y_o,
  output vcs_pkg::data_t                curve_z_o
);
  import vcs_pkg::*;

  localparam int KW    = $clog2(MAX_KNOTS);
  localparam int CW    = (KW + 1 > COUNT_W) ? KW + 1 : COUNT_W;
  localparam int CAW   = KW + AXIS_W + ORD_W;
  localparam int CDEPTH = MAX_KNOTS << (AXIS_W + ORD_W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_KRD  = 4'd3;
  localparam logic [3:0] S_FOFF = 4'd4;
  localparam logic [3:0] S_CLD  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_POST = 4'd7;

  logic [3:0]         state_q;
  logic [COUNT_W-1:0] count_q;
  logic [KW-1:0]      lo_q, hi_q;
  logic [1:0]         axis_q;
  logic [2:0]         rc_q;
  logic [1:0]         step_q;
  logic               done_q;
  data_t              param_q, f_q, opa_q, d_q;
  data_t              coef_q [4];
  data_t              pos_q [3];
  data_t              slope_q [3];
  data_t              curve_q [3];

  data_t              knot_mem [MAX_KNOTS];
  data_t              coeff_mem [CDEPTH];
  data_t              knot_rd_q, coeff_rd_q;

  logic               accept;
  logic               knot_we, coeff_we;
  logic [KW-1:0]      mid;
  logic [KW:0]        mid_sum;
  logic [KW-1:0]      knot_raddr;
  logic [CAW-1:0]     coeff_waddr, coeff_raddr;
  logic [CW-1:0]      kc_w, n_w;
  wide_t              prod, sh, p6, p3, c2x2;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign knot_we  = accept && (kind_i == KIND_KNOT) && (int'(index_i) < MAX_KNOTS);
  assign coeff_we = accept && (kind_i == KIND_COEFF) && (axis_i != AXIS_NONE) &&
                    (int'(index_i) < MAX_KNOTS - 1);

  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[KW:1];
  assign knot_raddr  = (state_q == S_SRCH) ? mid : lo_q;
  assign coeff_waddr = {KW'(index_i), axis_i, order_i};
  assign coeff_raddr = {lo_q, axis_q, rc_q[1:0]};

  always_ff @(posedge clk_i) begin
    if (knot_we) begin
      knot_mem[KW'(index_i)] <= value_i;
    end
    knot_rd_q <= knot_mem[knot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (coeff_we) begin
      coeff_mem[coeff_waddr] <= value_i;
    end
    coeff_rd_q <= coeff_mem[coeff_raddr];
  end

  always_comb begin
    kc_w = CW'(count_q);
    if (kc_w < CW'(2)) begin
      n_w = CW'(2);
    end else if (kc_w > CW'(MAX_KNOTS)) begin
      n_w = CW'(MAX_KNOTS);
    end else begin
      n_w = kc_w;
    end
  end

  vcs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (opa_q),
    .b_i    (f_q),
    .prod_o (prod)
  );

  assign sh   = prod >>> FRAC_BITS;
  assign p6   = (sh <<< 2) + (sh <<< 1);
  assign p3   = (sh <<< 1) + sh;
  assign c2x2 = wide_t'(coef_q[2]) <<< 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= COUNT_W'(2);
      done_q  <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      axis_q  <= '0;
      rc_q    <= '0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (kind_i == KIND_EVAL)) begin
            lo_q    <= '0;
            hi_q    <= KW'(n_w - CW'(1));
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if ({1'b0, lo_q} + 1'b1 == {1'b0, hi_q}) begin
            state_q <= S_KRD;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (knot_rd_q >= param_q) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_KRD: begin
          state_q <= S_FOFF;
        end
        S_FOFF: begin
          axis_q  <= '0;
          rc_q    <= '0;
          state_q <= S_CLD;
        end
        S_CLD: begin
          rc_q <= rc_q + 3'd1;
          if (rc_q == 3'd4) begin
            step_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_POST;
        end
        S_POST: begin
          step_q  <= step_q + 2'd1;
          state_q <= S_MUL;
          if (step_q == 2'd3) begin
            if (axis_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              rc_q    <= '0;
              state_q <= S_CLD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      param_q <= param_i;
    end
    if (state_q == S_FOFF) begin
      f_q <= sat32(wide_t'(param_q) - wide_t'(knot_rd_q));
    end
    if ((state_q == S_CLD) && (rc_q != 3'd0)) begin
      coef_q[rc_q[1:0] - 2'd1] <= coeff_rd_q;
      if (rc_q == 3'd4) begin
        opa_q <= coeff_rd_q;
      end
    end
    if (state_q == S_POST) begin
      unique case (step_q)
        2'd0: begin
          opa_q           <= sat32(sh + wide_t'(coef_q[2]));
          d_q             <= sat32(p3 + c2x2);
          curve_q[axis_q] <= sat32(p6 + c2x2);
        end
        2'd1: begin
          opa_q <= sat32(sh + wide_t'(coef_q[1]));
        end
        2'd2: begin
          pos_q[axis_q] <= sat32(sh + wide_t'(coef_q[0]));
          opa_q         <= d_q;
        end
        2'd3: begin
          slope_q[axis_q] <= sat32(sh + wide_t'(coef_q[1]));
        end
        default: begin
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign segment_o = SEG_W'(lo_q);
  assign pos_x_o   = pos_q[0];
  assign pos_y_o   = pos_q[1];
  assign pos_z_o   = pos_q[2];
  assign slope_x_o = slope_q[0];
  assign slope_y_o = slope_q[1];
  assign slope_z_o = slope_q[2];
  assign curve_x_o = curve_q[0];
  assign curve_y_o = curve_q[1];
  assign curve_z_o = curve_q[2];

endmodule

[sv/vcs_mul.sv]
`timescale 1ns / 1ps
module vcs_mul (
  input  logic                  clk_i,
  input  vcs_pkg::data_t        a_i,
  input  vcs_pkg::data_t        b_i,
  output vcs_pkg::wide_t        prod_o
);
  import vcs_pkg::*;

  wide_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= wide_t'(a_i) * wide_t'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[test/tb_vector_cubic_spline_eval.sv]
`timescale 1ns / 1ps
module tb_vector_cubic_spline_eval;
  import vcs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NKNOT = 64;
  localparam int NSEG = NKNOT - 1;
  localparam int DRAIN_CYC = 80;
  localparam int WDOG_LIMIT = 3000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [AXIS_W-1:0] axis;
    logic [ORD_W-1:0]  order;
    data_t             value;
    data_t             param;
    int                gap;
  } cmd_t;

  typedef struct {
    logic [SEG_W-1:0] segment;
    data_t            pos[3];
    data_t            slope[3];
    data_t            curve[3];
  } spline_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind_i = '0;
  logic [IDX_W-1:0] index_i = '0;
  logic [AXIS_W-1:0] axis_i = '0;
  logic [ORD_W-1:0] order_i = '0;
  data_t value_i = '0;
  data_t param_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [SEG_W-1:0] segment_o;
  data_t pos_x_o, pos_y_o, pos_z_o;
  data_t slope_x_o, slope_y_o, slope_z_o;
  data_t curve_x_o, curve_y_o, curve_z_o;

  vector_cubic_spline_eval i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .index_i    (index_i),
    .axis_i     (axis_i),
    .order_i    (order_i),
    .value_i    (value_i),
    .param_i    (param_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .segment_o  (segment_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .slope_x_o  (slope_x_o),
    .slope_y_o  (slope_y_o),
    .slope_z_o  (slope_z_o),
    .curve_x_o  (curve_x_o),
    .curve_y_o  (curve_y_o),
    .curve_z_o  (curve_z_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  cmd_t pending_cmds[$];
  spline_res_t expected_results[$];
  data_t knot_mem[NKNOT];
  data_t coeff_mem[NKNOT*12];
  logic [COUNT_W-1:0] knot_count = 7'd2;
  bit acc_seen = 0;
  bit cmd_active = 0;
  int wait_cnt = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_evals = 0;
  int n_writes = 0;
  int n_cfg = 0;
  bit no_idle = 0;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic spline_res_t eval_spline(input data_t prm);
    spline_res_t r;
    int n, lo, hi, mid, base;
    longint f, c0, c1, c2, c3, p, t, d;
    n = int'(knot_count);
    if (n < 2) n = 2;
    if (n > NKNOT) n = NKNOT;
    lo = 0;
    hi = n - 1;
    while (lo + 1 != hi) begin
      mid = (lo + hi) / 2;
      if (knot_mem[mid] >= prm) hi = mid;
      else lo = mid;
    end
    f = clip32(longint'(prm) - longint'(knot_mem[lo]));
    r.segment = lo[SEG_W-1:0];
    for (int a = 0; a < 3; a++) begin
      base = (lo * 3 + a) * 4;
      c0 = longint'(coeff_mem[base]);
      c1 = longint'(coeff_mem[base+1]);
      c2 = longint'(coeff_mem[base+2]);
      c3 = longint'(coeff_mem[base+3]);
      p = (c3 * f) >>> FRAC_BITS_DEF;
      t = clip32(p + c2);
      t = clip32(((t * f) >>> FRAC_BITS_DEF) + c1);
      r.pos[a] = data_t'(clip32(((t * f) >>> FRAC_BITS_DEF) + c0));
      d = clip32(3 * p + 2 * c2);
      r.slope[a] = data_t'(clip32(((d * f) >>> FRAC_BITS_DEF) + c1));
      r.curve[a] = data_t'(clip32(6 * p + 2 * c2));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0d (%h) got %0d (%h)", $realtime, name,
                 expv, expv[31:0], actv, actv[31:0]);
    end
  endtask

  // accept side: predictor update, result check, watchdog
  always @(posedge clk_i) begin
    spline_res_t got, want;
    bit moved;
    moved = 0;
    if (rst_ni && start && !busy) begin
      moved = 1;
      acc_seen = 1;
      void'(pending_cmds.pop_front());
      case (kind_i)
        KIND_KNOT: begin
          knot_mem[index_i] = value_i;
          n_writes++;
        end
        KIND_COEFF: begin
          if (axis_i != AXIS_NONE && int'(index_i) < NSEG)
            coeff_mem[(int'(index_i) * 3 + int'(axis_i)) * 4 + int'(order_i)] = value_i;
          n_writes++;
        end
        KIND_EVAL: begin
          expected_results.push_back(eval_spline(param_i));
          n_evals++;
        end
        default: ;
      endcase
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) moved = 1;
    if (rst_ni && done_o) begin
      moved = 1;
      got.segment = segment_o;
      got.pos = '{pos_x_o, pos_y_o, pos_z_o};
      got.slope = '{slope_x_o, slope_y_o, slope_z_o};
      got.curve = '{curve_x_o, curve_y_o, curve_z_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t unexpected result transfer", $realtime);
      end else begin
        want = expected_results.pop_front();
        check_field("segment", want.segment, got.segment);
        for (int a = 0; a < 3; a++) begin
          check_field($sformatf("pos[%0d]", a), want.pos[a], got.pos[a]);
          check_field($sformatf("slope[%0d]", a), want.slope[a], got.slope[a]);
          check_field($sformatf("curve[%0d]", a), want.curve[a], got.curve[a]);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // command driver
  always @(negedge clk_i) begin
    if (acc_seen) begin
      acc_seen = 0;
      cmd_active = 0;
    end
    if (rst_ni && !cmd_active && pending_cmds.size() > 0) begin
      if (wait_cnt >= pending_cmds[0].gap) begin
        kind_i <= pending_cmds[0].kind;
        index_i <= pending_cmds[0].index;
        axis_i <= pending_cmds[0].axis;
        order_i <= pending_cmds[0].order;
        value_i <= pending_cmds[0].value;
        param_i <= pending_cmds[0].param;
        cmd_active = 1;
        wait_cnt = 0;
      end else begin
        wait_cnt++;
      end
    end
    start <= cmd_active;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic data_t rand_coeff();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return data_t'($urandom);
      default: return data_t'(int'($urandom_range(0, 32'h3ffff)) - 32'h20000);
    endcase
  endfunction

  function automatic cmd_t mk_cmd(input logic [KIND_W-1:0] k, input int idx, input int ax,
                                  input int ord, input data_t v, input data_t prm);
    cmd_t c;
    c.kind = k;
    c.index = idx[IDX_W-1:0];
    c.axis = ax[AXIS_W-1:0];
    c.order = ord[ORD_W-1:0];
    c.value = v;
    c.param = prm;
    c.gap = draw_gap();
    return c;
  endfunction

  function automatic data_t rand_param();
    int k;
    k = $urandom_range(0, NKNOT - 2);
    case ($urandom_range(0, 9))
      0: return data_t'($urandom);
      1: return knot_mem[k];
      2: return 32'sh80000000;
      3: return 32'sh7fffffff;
      default: return knot_mem[k] + data_t'($urandom_range(0, 32'h3ffff));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70)
      return mk_cmd(KIND_EVAL, $urandom_range(0, 63), $urandom_range(0, 3),
                    $urandom_range(0, 3), data_t'($urandom), rand_param());
    if (sel < 88)
      return mk_cmd(KIND_COEFF, $urandom_range(0, 63), $urandom_range(0, 3),
                    $urandom_range(0, 3), rand_coeff(), data_t'($urandom));
    if (sel < 95) begin
      int k;
      k = $urandom_range(0, 63);
      return mk_cmd(KIND_KNOT, k, $urandom_range(0, 3), $urandom_range(0, 3),
                    ($urandom_range(0, 3) == 0) ? data_t'($urandom)
                      : data_t'(((k * 2 - 64) <<< 16) + $urandom_range(0, 32'hffff)),
                    data_t'($urandom));
    end
    return mk_cmd(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 3),
                  $urandom_range(0, 3), data_t'($urandom), data_t'($urandom));
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || cmd_active || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    knot_count = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] counts[8];
    counts = '{7'd2, 7'd64, 7'd127, 7'd0, 7'd3, 7'd33, 7'd65, 7'd17};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_count(7'd64);

    // load every entry that an evaluation can read, knots ascending
    for (int k = 0; k < NKNOT; k++)
      pending_cmds.push_back(mk_cmd(KIND_KNOT, k, 0, 0,
                                    data_t'(((k * 2 - 64) <<< 16) + $urandom_range(0, 32'hffff)),
                                    '0));
    for (int s = 0; s < NSEG; s++)
      for (int a = 0; a < 3; a++)
        for (int o = 0; o < 4; o++)
          pending_cmds.push_back(mk_cmd(KIND_COEFF, s, a, o, rand_coeff(), '0));
    drain();

    // directed corners
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, 32'sh80000000));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 63, 3, 3, '1, 32'sh7fffffff));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, knot_mem[0]));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, knot_mem[31]));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, knot_mem[62] + 1));
    pending_cmds.push_back(mk_cmd(KIND_COEFF, 63, 0, 0, 32'sh7fffffff, '0));
    pending_cmds.push_back(mk_cmd(KIND_COEFF, 5, 3, 2, 32'sh80000000, '0));
    pending_cmds.push_back(mk_cmd(KIND_UNUSED, 63, 3, 3, '1, '1));
    for (int o = 0; o < 4; o++)
      pending_cmds.push_back(mk_cmd(KIND_COEFF, 0, 0, o, 32'sh7fffffff, '0));
    for (int o = 0; o < 4; o++)
      pending_cmds.push_back(mk_cmd(KIND_COEFF, 0, 2, o, 32'sh80000000, '0));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, 32'sh7fffffff));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, 32'sh80000000));
    pending_cmds.push_back(mk_cmd(KIND_KNOT, 63, 0, 0, 32'sh80000000, '0));
    pending_cmds.push_back(mk_cmd(KIND_KNOT, 40, 0, 0, 32'sh7fffffff, '0));
    pending_cmds.push_back(mk_cmd(KIND_EVAL, 0, 0, 0, '0, '0));
    pending_cmds.push_back(mk_cmd(KIND_KNOT, 40, 0, 0, 32'sh00100000, '0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_count(counts[ph]);
      no_idle = (ph % 3 == 1);
      for (int i = 0; i < 108; i++) pending_cmds.push_back(rand_cmd());
      drain();
    end

    $display("covered %0d evaluations, %0d table writes, %0d knot count settings",
             n_evals, n_writes, n_cfg);
    $display("knot counts swept from below 2 to above 64, with saturating coefficients");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
